### design/cd_pkg.sv
// Shared types and codes for the circular deque.
package cd_pkg;

  localparam int DATA_W = 32;
  localparam int ACT_W  = 3;
  localparam int STAT_W = 2;
  localparam int SIZE_W = 4;
  localparam int IN_W   = 40;
  localparam int OUT_W  = 40;

  localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_PEEK_FRONT = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic load;   // capture request from the input transfer
    logic exec;   // update indices, access slot memory
  } cd_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cd_stat_t;

endpackage

### design/cd_ctrl.sv
// Request sequencer: idle, execute, hold result.
module cd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  cd_pkg::cd_stat_t dp_stat,
  output cd_pkg::cd_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_RESP);
  assign cmd.load  = in_ready && in_valid;
  assign cmd.exec  = (state == S_EXEC);

`ifndef NO_ASSERTIONS
  a_load_then_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.exec)
    else $error("request not executed after capture");
  a_never_full_and_empty: assert property (@(posedge clk) disable iff (rst)
    !(dp_stat.full && dp_stat.empty))
    else $error("deque reported both full and empty");
`endif

endmodule

### design/cd_dpath.sv
// Deque datapath: slot memory, head/tail indices, size register, result registers.
module cd_dpath #(
  parameter int DEPTH = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cd_pkg::cd_cmd_t             cmd,
  output cd_pkg::cd_stat_t            dp_stat,
  input  logic                        cfg_we,
  input  logic [cd_pkg::SIZE_W-1:0]   cfg_size,
  input  logic [cd_pkg::ACT_W-1:0]    req_action,
  input  logic [cd_pkg::DATA_W-1:0]   req_data,
  output logic [cd_pkg::DATA_W-1:0]   data_out,
  output logic [cd_pkg::STAT_W-1:0]   status
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = (CW > cd_pkg::SIZE_W) ? CW : cd_pkg::SIZE_W;

  logic [cd_pkg::DATA_W-1:0] mem [DEPTH];

  logic [CW-1:0]             size_eff;
  logic [IW-1:0]             head;
  logic [IW-1:0]             tail;
  logic                      empty;
  logic [cd_pkg::ACT_W-1:0]  act_q;
  logic [cd_pkg::DATA_W-1:0] din_q;
  logic [cd_pkg::DATA_W-1:0] rd_q;
  logic [cd_pkg::STAT_W-1:0] stat_q;
  logic                      hit_q;

  logic [IW-1:0]             head_next;
  logic [IW-1:0]             tail_next;
  logic                      empty_next;
  logic [cd_pkg::STAT_W-1:0] stat_next;
  logic                      hit_next;
  logic                      wr_en;
  logic [IW-1:0]             wr_addr;
  logic [IW-1:0]             rd_addr;
  logic                      full;
  logic [SW-1:0]             cfg_ext;
  logic [CW-1:0]             cfg_eff;

  function automatic logic [IW-1:0] step_fwd(input logic [IW-1:0] i,
                                             input logic [CW-1:0] sz);
    logic [CW-1:0] n;
    n = CW'(i) + CW'(1);
    return (n >= sz) ? '0 : IW'(n);
  endfunction

  function automatic logic [IW-1:0] step_back(input logic [IW-1:0] i,
                                              input logic [CW-1:0] sz);
    return (i == '0) ? IW'(sz - CW'(1)) : i - IW'(1);
  endfunction

  assign full = !empty && (head == step_fwd(tail, size_eff));

  // size 0 acts as 1, sizes above the built depth act as the depth
  assign cfg_ext = SW'(cfg_size);
  always_comb begin
    if (cfg_ext == '0) begin
      cfg_eff = CW'(1);
    end else if (cfg_ext > SW'(DEPTH)) begin
      cfg_eff = CW'(DEPTH);
    end else begin
      cfg_eff = CW'(cfg_ext);
    end
  end

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    empty_next = empty;
    stat_next  = cd_pkg::ST_OK;
    hit_next   = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    rd_addr    = (act_q == cd_pkg::ACT_POP_BACK) ? tail : head;
    case (act_q)
      cd_pkg::ACT_PUSH_BACK, cd_pkg::ACT_PUSH_FRONT: begin
        if (full) begin
          stat_next = cd_pkg::ST_FULL;
        end else if (empty) begin
          head_next  = '0;
          tail_next  = '0;
          empty_next = 1'b0;
          wr_en      = 1'b1;
          wr_addr    = '0;
        end else if (act_q == cd_pkg::ACT_PUSH_BACK) begin
          tail_next = step_fwd(tail, size_eff);
          wr_en     = 1'b1;
          wr_addr   = tail_next;
        end else begin
          head_next = step_back(head, size_eff);
          wr_en     = 1'b1;
          wr_addr   = head_next;
        end
      end
      cd_pkg::ACT_POP_FRONT, cd_pkg::ACT_POP_BACK: begin
        if (empty) begin
          stat_next = cd_pkg::ST_EMPTY;
        end else begin
          hit_next = 1'b1;
          if (head == tail) begin
            head_next  = '0;
            tail_next  = '0;
            empty_next = 1'b1;
          end else if (act_q == cd_pkg::ACT_POP_FRONT) begin
            head_next = step_fwd(head, size_eff);
          end else begin
            tail_next = step_back(tail, size_eff);
          end
        end
      end
      cd_pkg::ACT_PEEK_FRONT: begin
        if (empty) begin
          stat_next = cd_pkg::ST_EMPTY;
        end else begin
          hit_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      size_eff <= CW'(DEPTH);
      head     <= '0;
      tail     <= '0;
      empty    <= 1'b1;
    end else begin
      if (cfg_we) size_eff <= cfg_eff;
      if (cmd.exec) begin
        head  <= head_next;
        tail  <= tail_next;
        empty <= empty_next;
      end
    end
  end

  // request capture and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q <= req_action;
      din_q <= req_data;
    end
    if (cmd.exec) begin
      stat_q <= stat_next;
      hit_q  <= hit_next;
    end
  end

  // slot memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) mem[wr_addr] <= din_q;
    if (cmd.exec) rd_q <= mem[rd_addr];
  end

  assign data_out      = hit_q ? rd_q : '0;
  assign status        = stat_q;
  assign dp_stat.full  = full;
  assign dp_stat.empty = empty;

`ifndef NO_ASSERTIONS
  a_empty_indices: assert property (@(posedge clk) disable iff (rst)
    empty |-> (head == '0 && tail == '0))
    else $error("empty deque with nonzero index");
  a_size_range: assert property (@(posedge clk) disable iff (rst)
    (size_eff != '0) && (size_eff <= CW'(DEPTH)))
    else $error("effective size out of range");
  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && (act_q == cd_pkg::ACT_PUSH_BACK || act_q == cd_pkg::ACT_PUSH_FRONT)
    |=> !empty)
    else $error("deque empty after push");
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && empty && (act_q == cd_pkg::ACT_POP_FRONT || act_q == cd_pkg::ACT_POP_BACK)
    |=> (stat_q == cd_pkg::ST_EMPTY) && empty && !hit_q)
    else $error("pop on empty deque not refused");
`endif

endmodule

### design/circular_deque.sv
// Double-ended queue over a ring of signed 32-bit slots, top level.
//
// Requests enter on the s_ stream: s_tdata holds the action code and the value
// to push. Each request yields exactly one result on the m_ stream: the value
// removed or peeked (zero on pushes and refusals) and a status of ok, full or
// empty. The cfg channel writes the number of ring slots in use (0 acts as 1,
// anything above DEPTH acts as DEPTH); cfg_ready is always high, and writes
// belong between requests.
// Timing: a request transfer moves the block to execute; in the cycle after
// that the result is presented on m_tvalid, and a new request is taken only
// once the result transfer has completed, so requests never overlap. This
// follows from the registered read of the slot memory and the
// one-request-at-a-time sequencer.
// Reset (rst, synchronous): queue empty, both indices zero, size DEPTH; slot
// contents are not cleared.
// When the receiver stalls, the result is held on m_tdata and s_tready stays
// low until the result transfer completes.
module circular_deque #(
  parameter int DEPTH = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [cd_pkg::IN_W-1:0]      s_tdata,   // action[2:0], data_in[34:3], zero pad
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [cd_pkg::OUT_W-1:0]     m_tdata,   // data_out[31:0], status[33:32], zero pad
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [cd_pkg::SIZE_W-1:0]    cfg_data   // size_in_use
);

  cd_pkg::cd_cmd_t            cmd;
  cd_pkg::cd_stat_t           dp_stat;
  logic [cd_pkg::DATA_W-1:0]  data_out;
  logic [cd_pkg::STAT_W-1:0]  status;

  assign cfg_ready = 1'b1;

  cd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .dp_stat   (dp_stat),
    .cmd       (cmd)
  );

  cd_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .dp_stat    (dp_stat),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_size   (cfg_data),
    .req_action (s_tdata[cd_pkg::ACT_W-1:0]),
    .req_data   (s_tdata[cd_pkg::ACT_W +: cd_pkg::DATA_W]),
    .data_out   (data_out),
    .status     (status)
  );

  assign m_tdata = {{(cd_pkg::OUT_W - cd_pkg::DATA_W - cd_pkg::STAT_W){1'b0}},
                    status, data_out};

endmodule
